>>> hdl/apdu_report_framer_deframer_unit_assert.svh
// ----------------------------------------------------------------------------
// apdu framer/deframer assertion macros
// concurrent checks that compile away when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef APDU_REPORT_FRAMER_DEFRAMER_UNIT_ASSERT_SVH
`define APDU_REPORT_FRAMER_DEFRAMER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define APDUFD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define APDUFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define APDUFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define APDUFD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define APDUFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define APDUFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hdl/apdufd_pkg.sv
// ----------------------------------------------------------------------------
// apdufd_pkg
// word types, result kinds and report layout for the apdu framer/deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package apdufd_pkg;

    // operation codes
    localparam logic OP_CMD = 1'b0;
    localparam logic OP_RX  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_REPORT = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // report byte offsets
    localparam int OFS_TIMEOUT = 0;
    localparam int OFS_PCB     = 1;
    localparam int OFS_LEN     = 3;
    localparam int OFS_PAYLOAD = 4;

    // pcb bits and the skip marker
    localparam logic [7:0] PCB_SEQ  = 8'h40;
    localparam logic [7:0] PCB_MORE = 8'h20;
    localparam logic [7:0] PCB_SKIP = 8'hCC;

    // register map
    localparam int         PADDR_W     = 3;
    localparam logic       REG_TIMEOUT = 1'b0;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
        logic       cmd_last;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  out_byte;
        logic [15:0] status_word;
        logic [15:0] resp_length;
        logic        out_last;
    } t_out_word;

    // what one received byte gives
    typedef struct packed {
        logic        data_en;
        logic [7:0]  data_byte;
        logic        fin_en;
        logic [1:0]  fin_kind;
        logic [15:0] status_word;
        logic [15:0] resp_length;
    } t_rx_evt;

endpackage

`default_nettype wire

>>> hdl/apdufd_rx_track.sv
// ----------------------------------------------------------------------------
// apdufd_rx_track
// follows received reports byte by byte, holds back the last two payload
// bytes and reports data release and response completion
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apdufd_rx_track #(
    parameter int REPORT_BYTES  = 64,
    parameter int BLOCK_PAYLOAD = 60
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire logic [7:0]        i_byte,
    output apdufd_pkg::t_rx_evt    o_evt
);
    import apdufd_pkg::*;

    localparam int PW = $clog2(REPORT_BYTES);
    localparam int FW = $clog2(BLOCK_PAYLOAD + 1);

    logic [PW-1:0] r_pos;
    logic [7:0]    r_ctrl;
    logic [FW-1:0] r_len;
    logic [7:0]    r_held0;
    logic [7:0]    r_held1;
    logic [15:0]   r_total;

    logic          payload_hit;
    logic          at_end;
    logic          fin_en;
    logic [15:0]   n_total;
    logic [7:0]    n_held0;
    logic [7:0]    n_held1;
    logic [FW-1:0] len_clamped;

    always_comb begin
        payload_hit = (int'(r_pos) >= OFS_PAYLOAD) && (r_ctrl != PCB_SKIP) &&
                      (int'(r_pos) < int'(r_len) + OFS_PAYLOAD);
        at_end      = (r_pos == PW'(REPORT_BYTES - 1));
        fin_en      = at_end && (r_ctrl != PCB_SKIP) && ((r_ctrl & PCB_MORE) == 8'h00);
        n_total     = r_total;
        n_held0     = r_held0;
        n_held1     = r_held1;
        if (payload_hit) begin
            n_held0 = r_held1;
            n_held1 = i_byte;
            if (r_total != 16'hFFFF) begin
                n_total = r_total + 16'd1;
            end
        end
        if (int'(i_byte) > BLOCK_PAYLOAD) begin
            len_clamped = FW'(BLOCK_PAYLOAD);
        end else begin
            len_clamped = FW'(i_byte);
        end

        o_evt.data_en   = payload_hit && (r_total >= 16'd2);
        o_evt.data_byte = r_held0;
        o_evt.fin_en    = fin_en;
        if (n_total >= 16'd2) begin
            o_evt.fin_kind    = KIND_DONE;
            o_evt.status_word = {n_held0, n_held1};
            o_evt.resp_length = n_total - 16'd2;
        end else begin
            o_evt.fin_kind    = KIND_ERROR;
            o_evt.status_word = '0;
            o_evt.resp_length = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_ctrl  <= '0;
            r_len   <= '0;
            r_total <= '0;
        end else if (i_take) begin
            if (r_pos == PW'(OFS_PCB)) begin
                r_ctrl <= i_byte;
            end
            if (r_pos == PW'(OFS_LEN)) begin
                r_len <= len_clamped;
            end
            r_held0 <= n_held0;
            r_held1 <= n_held1;
            if (at_end) begin
                r_pos   <= '0;
                r_total <= fin_en ? 16'd0 : n_total;
            end else begin
                r_pos   <= r_pos + PW'(1);
                r_total <= n_total;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/apdu_report_framer_deframer_unit.sv
// ----------------------------------------------------------------------------
// apdu_report_framer_deframer_unit
// cuts command bytes into fixed-size reports and reassembles received
// reports into response data, status word and length
// ----------------------------------------------------------------------------
// channel   dir  handshake                words
// in        in   i_in_valid / o_in_stall  t_in_word, one byte per word
// out       out  o_out_valid / i_out_stall t_out_word, one result per word
// apb       in   psel/penable/pready      timeout_code at byte address 0
//
// a byte that closes no block is taken while idle; a received byte that ends a
// response with data pending gives a data word and then a completion word
// a closed block streams REPORT_BYTES words from the payload memory, input
// stalled meanwhile
// reset is synchronous and clears control state only, no clearing pass
// a stall on the output holds the whole block until the word is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apdu_report_framer_deframer_unit #(
    parameter int REPORT_BYTES  = 64,
    parameter int BLOCK_PAYLOAD = 60
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire apdufd_pkg::t_in_word          i_in_word,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output apdufd_pkg::t_out_word              o_out_word,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [apdufd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import apdufd_pkg::*;

    `include "apdu_report_framer_deframer_unit_assert.svh"

    localparam int PW = $clog2(REPORT_BYTES);
    localparam int FW = $clog2(BLOCK_PAYLOAD + 1);
    localparam int AW = $clog2(BLOCK_PAYLOAD);
    localparam logic [PW-1:0] LAST_IDX = PW'(REPORT_BYTES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TX,
        S_RX_DONE
    } t_state;

    t_state        r_state;
    logic [7:0]    r_timeout;
    logic [FW-1:0] r_fill;
    logic [7:0]    r_block;
    logic          r_toggle;
    logic [7:0]    r_pcb;
    logic [FW-1:0] r_len;
    logic [PW-1:0] r_idx;
    logic          r_out_valid;
    t_out_word     r_out;
    t_out_word     r_pend;
    logic [7:0]    r_rdata;

    logic [7:0]    mem [BLOCK_PAYLOAD];

    t_rx_evt       rx_evt;
    t_out_word     fin_word;
    logic          out_free;
    logic          in_acc;
    logic          cmd_acc;
    logic          rx_acc;
    logic          fill_room;
    logic [FW-1:0] fill_next;
    logic          full_next;
    logic          send_now;
    logic          more;
    logic [7:0]    pcb;
    logic          tx_emit;
    logic [PW-1:0] n_idx;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    tx_byte;
    logic          cfg_wr;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && out_free);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign cmd_acc     = in_acc && (i_in_word.operation == OP_CMD);
    assign rx_acc      = in_acc && (i_in_word.operation == OP_RX);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite && (paddr[2] == REG_TIMEOUT);
    assign prdata      = (paddr[2] == REG_TIMEOUT) ? {24'd0, r_timeout} : 32'd0;

    always_comb begin
        fill_room = (r_fill < FW'(BLOCK_PAYLOAD));
        fill_next = r_fill + FW'(fill_room);
        full_next = (fill_next == FW'(BLOCK_PAYLOAD));
        send_now  = cmd_acc && (i_in_word.cmd_last || full_next);
        more      = !i_in_word.cmd_last && full_next;
        pcb       = (r_toggle ? PCB_SEQ : 8'h00) + (more ? PCB_MORE : 8'h00) + r_block;
        tx_emit   = (r_state == S_TX) && out_free;

        // read address follows the index of the next word so the data lines up
        if (send_now) begin
            n_idx = '0;
        end else if (tx_emit) begin
            n_idx = r_idx + PW'(1);
        end else begin
            n_idx = r_idx;
        end
        rd_en   = (int'(n_idx) >= OFS_PAYLOAD) && (int'(n_idx) < BLOCK_PAYLOAD + OFS_PAYLOAD);
        rd_addr = AW'(n_idx - PW'(OFS_PAYLOAD));

        priority if (r_idx == PW'(OFS_TIMEOUT)) begin
            tx_byte = r_timeout;
        end else if (r_idx == PW'(OFS_PCB)) begin
            tx_byte = r_pcb;
        end else if (r_idx == PW'(OFS_LEN)) begin
            tx_byte = 8'(r_len);
        end else if ((int'(r_idx) >= OFS_PAYLOAD) &&
                     (int'(r_idx) < int'(r_len) + OFS_PAYLOAD)) begin
            tx_byte = r_rdata;
        end else begin
            tx_byte = 8'h00;
        end

        fin_word.out_kind    = rx_evt.fin_kind;
        fin_word.out_byte    = 8'h00;
        fin_word.status_word = rx_evt.status_word;
        fin_word.resp_length = rx_evt.resp_length;
        fin_word.out_last    = 1'b1;
    end

    apdufd_rx_track #(
        .REPORT_BYTES  (REPORT_BYTES),
        .BLOCK_PAYLOAD (BLOCK_PAYLOAD)
    ) u_rx_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (rx_acc),
        .i_byte  (i_in_word.data_byte),
        .o_evt   (rx_evt)
    );

    // payload memory
    always_ff @(posedge i_clk) begin
        if (cmd_acc && fill_room) begin
            mem[AW'(r_fill)] <= i_in_word.data_byte;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_timeout   <= '0;
            r_fill      <= '0;
            r_block     <= '0;
            r_toggle    <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_timeout <= pwdata[7:0];
            end
            if (out_free) begin
                r_out_valid <= 1'b0;
            end
            r_idx <= n_idx;
            unique case (r_state)
                S_IDLE: begin
                    if (cmd_acc) begin
                        r_fill <= fill_next;
                        if (send_now) begin
                            r_pcb    <= pcb;
                            r_len    <= fill_next;
                            r_fill   <= '0;
                            r_block  <= i_in_word.cmd_last ? 8'h00 : r_block + 8'h01;
                            r_toggle <= i_in_word.cmd_last ? 1'b0 : !r_toggle;
                            r_state  <= S_TX;
                        end
                    end
                    if (rx_acc) begin
                        if (rx_evt.data_en) begin
                            r_out_valid          <= 1'b1;
                            r_out.out_kind       <= KIND_DATA;
                            r_out.out_byte       <= rx_evt.data_byte;
                            r_out.status_word    <= '0;
                            r_out.resp_length    <= '0;
                            r_out.out_last       <= !rx_evt.fin_en;
                            if (rx_evt.fin_en) begin
                                r_pend  <= fin_word;
                                r_state <= S_RX_DONE;
                            end
                        end else if (rx_evt.fin_en) begin
                            r_out_valid <= 1'b1;
                            r_out       <= fin_word;
                        end
                    end
                end
                S_TX: begin
                    if (out_free) begin
                        r_out_valid       <= 1'b1;
                        r_out.out_kind    <= KIND_REPORT;
                        r_out.out_byte    <= tx_byte;
                        r_out.status_word <= '0;
                        r_out.resp_length <= '0;
                        r_out.out_last    <= (r_idx == LAST_IDX);
                        if (r_idx == LAST_IDX) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_RX_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= r_pend;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // input is held off for the whole report
    `APDUFD_ASSERT_IMPL(a_tx_stalls_input, i_clk, i_rst_n, r_state == S_TX, o_in_stall, "input taken during report")
    // fill count never passes the block size
    `APDUFD_ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= FW'(BLOCK_PAYLOAD), "fill count out of range")
    // last report word returns to idle
    `APDUFD_ASSERT_NEXT(a_tx_end, i_clk, i_rst_n, tx_emit && (r_idx == LAST_IDX), r_state == S_IDLE, "report did not end")
    // a pending completion always sits behind a data word
    `APDUFD_ASSERT_IMPL(a_pend_behind_data, i_clk, i_rst_n, r_state == S_RX_DONE, r_out_valid, "completion pending without data word")

endmodule

`default_nettype wire
